### hw/rtl/rcd_pkg.sv
// rcd_pkg: shared constants, widths, codes and types of the rectangle center dedup block
// no dependencies; used by every other file of the block

package rcd_pkg;

  // geometry and table size
  localparam int unsigned COORD_BITS  = 12;
  localparam int unsigned TABLE_DEPTH = 64;
  localparam int unsigned FRAC        = 16;
  localparam int unsigned SLOT_BITS   = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CNT_BITS    = $clog2(TABLE_DEPTH + 1);

  // configuration port
  localparam int unsigned MARGIN_BITS   = 12;
  localparam int unsigned CFG_IDX_BITS  = 1;
  localparam int unsigned CFG_DATA_BITS = 12;
  localparam int unsigned MARGIN_RESET  = 10;
  localparam int unsigned CMP_W = (COORD_BITS > MARGIN_BITS) ? COORD_BITS : MARGIN_BITS;

  // fixed point widths
  localparam int unsigned M_W    = COORD_BITS + FRAC + 1;      // signed slope
  localparam int unsigned UM_W   = M_W - 1;                    // slope magnitude
  localparam int unsigned A_W    = 2 * COORD_BITS + FRAC + 2;  // signed intercept
  localparam int unsigned NUM_W  = A_W + 1;                    // intercept difference
  localparam int unsigned UN_W   = A_W;                        // its magnitude
  localparam int unsigned DEN_W  = M_W + 1;                    // slope difference
  localparam int unsigned UD_W   = M_W;                        // its magnitude
  localparam int unsigned DVD_W  = UN_W + FRAC;                // divider dividend
  localparam int unsigned STEP_W = $clog2(DVD_W + 1);
  localparam int unsigned XH_W   = DVD_W - FRAC;
  localparam int unsigned ACCH_W = UM_W + XH_W;
  localparam int unsigned ACCL_W = UM_W + FRAC;
  localparam int unsigned Y_W    = 64;
  localparam int unsigned SAT_SHIFT = 60;
  localparam int unsigned SAT_W  = (ACCH_W > Y_W) ? ACCH_W : Y_W;
  localparam int unsigned SLOPE_EPS = 328;

  // result status codes
  typedef enum logic [1:0] {
    STAT_UNIQUE   = 2'd0,
    STAT_DUP      = 2'd1,
    STAT_NOCENTER = 2'd2,
    STAT_FULL     = 2'd3
  } status_e;

  // configuration register indexes
  typedef enum logic [CFG_IDX_BITS-1:0] {
    CFG_MARGIN_X = 1'b0,
    CFG_MARGIN_Y = 1'b1
  } cfg_idx_e;

  // sequencer states
  typedef enum logic [3:0] {
    ST_IDLE,
    ST_FIT,
    ST_SLOPE,
    ST_ICEPT,
    ST_CROSS,
    ST_XDIV,
    ST_MUL,
    ST_YCALC,
    ST_TSTART,
    ST_SCAN,
    ST_DONE
  } state_e;

  // divider command
  typedef struct packed {
    logic              start;
    logic [STEP_W-1:0] steps;
  } div_cmd_t;

  // table lookup outcome
  typedef struct packed {
    status_e              status;
    logic [SLOT_BITS-1:0] slot;
  } tbl_res_t;

endpackage

### hw/rtl/rcd_if.sv
// rcd_if: valid/ready channel interfaces for quadrilateral requests and center results
// depends on rcd_pkg for field widths and the status type

interface rcd_in_if;
  logic                         valid;
  logic                         ready;
  logic [rcd_pkg::COORD_BITS-1:0] corner0_x;
  logic [rcd_pkg::COORD_BITS-1:0] corner0_y;
  logic [rcd_pkg::COORD_BITS-1:0] corner1_x;
  logic [rcd_pkg::COORD_BITS-1:0] corner1_y;
  logic [rcd_pkg::COORD_BITS-1:0] corner2_x;
  logic [rcd_pkg::COORD_BITS-1:0] corner2_y;
  logic [rcd_pkg::COORD_BITS-1:0] corner3_x;
  logic [rcd_pkg::COORD_BITS-1:0] corner3_y;

  modport source (
    output valid, corner0_x, corner0_y, corner1_x, corner1_y,
           corner2_x, corner2_y, corner3_x, corner3_y,
    input  ready
  );
  modport sink (
    input  valid, corner0_x, corner0_y, corner1_x, corner1_y,
           corner2_x, corner2_y, corner3_x, corner3_y,
    output ready
  );
endinterface

interface rcd_out_if;
  logic                          valid;
  logic                          ready;
  rcd_pkg::status_e              status;
  logic [rcd_pkg::COORD_BITS-1:0] center_x;
  logic [rcd_pkg::COORD_BITS-1:0] center_y;
  logic [rcd_pkg::SLOT_BITS-1:0]  match_slot;

  modport source (
    output valid, status, center_x, center_y, match_slot,
    input  ready
  );
  modport sink (
    input  valid, status, center_x, center_y, match_slot,
    output ready
  );
endinterface

### hw/rtl/rcd_div.sv
// rcd_div: restoring divider, one quotient bit per cycle, left-aligned dividend
// depends on rcd_pkg for widths and the command struct

module rcd_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  rcd_pkg::div_cmd_t           cmd_i,
  input  logic [rcd_pkg::DVD_W-1:0]   dividend_i,
  input  logic [rcd_pkg::UD_W-1:0]    divisor_i,
  output logic                        done_o,
  output logic [rcd_pkg::DVD_W-1:0]   quot_o
);

  logic                         busy_q;
  logic                         done_q;
  logic [rcd_pkg::STEP_W-1:0]   cnt_q;
  logic [rcd_pkg::DVD_W-1:0]    dvd_q;
  logic [rcd_pkg::UD_W-1:0]     dsr_q;
  logic [rcd_pkg::UD_W-1:0]     rem_q;
  logic [rcd_pkg::UD_W-1:0]     rem_d;
  logic [rcd_pkg::DVD_W-1:0]    quot_q;
  logic [rcd_pkg::UD_W:0]       trial;
  logic                         qbit;

  // one restoring step
  always_comb begin
    trial = {rem_q, dvd_q[rcd_pkg::DVD_W-1]};
    qbit  = (trial >= {1'b0, dsr_q});
    if (qbit) begin
      rem_d = rcd_pkg::UD_W'(trial - {1'b0, dsr_q});
    end else begin
      rem_d = trial[rcd_pkg::UD_W-1:0];
    end
  end

  // step counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= !cmd_i.start && busy_q && (cnt_q == rcd_pkg::STEP_W'(1));
      if (cmd_i.start) begin
        busy_q <= 1'b1;
        cnt_q  <= cmd_i.steps;
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == rcd_pkg::STEP_W'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // operand and quotient shift registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.start) begin
      dvd_q  <= dividend_i;
      dsr_q  <= divisor_i;
      rem_q  <= '0;
      quot_q <= '0;
    end else if (busy_q) begin
      dvd_q  <= {dvd_q[rcd_pkg::DVD_W-2:0], 1'b0};
      rem_q  <= rem_d;
      quot_q <= {quot_q[rcd_pkg::DVD_W-2:0], qbit};
    end
  end

  assign done_o = done_q;
  assign quot_o = quot_q;

endmodule

### hw/rtl/rcd_mul.sv
// rcd_mul: shift-add multiplier of the slope magnitude by the crossing x, msb first
// depends on rcd_pkg for widths

module rcd_mul (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [rcd_pkg::UM_W-1:0]    a_i,
  input  logic [rcd_pkg::XH_W-1:0]    bh_i,
  input  logic [rcd_pkg::FRAC-1:0]    bl_i,
  output logic                        done_o,
  output logic [rcd_pkg::ACCH_W-1:0]  acc_h_o,
  output logic [rcd_pkg::ACCL_W-1:0]  acc_l_o
);

  localparam int unsigned CNT_W = $clog2(rcd_pkg::UM_W + 1);

  logic                        busy_q;
  logic                        done_q;
  logic [CNT_W-1:0]            cnt_q;
  logic [rcd_pkg::UM_W-1:0]    a_q;
  logic [rcd_pkg::XH_W-1:0]    bh_q;
  logic [rcd_pkg::FRAC-1:0]    bl_q;
  logic [rcd_pkg::ACCH_W-1:0]  acc_h_q;
  logic [rcd_pkg::ACCL_W-1:0]  acc_l_q;

  // bit counter
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= !start_i && busy_q && (cnt_q == CNT_W'(1));
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(rcd_pkg::UM_W);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == CNT_W'(1)) begin
          busy_q <= 1'b0;
        end
      end
    end
  end

  // accumulate high and low partial products
  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q     <= a_i;
      bh_q    <= bh_i;
      bl_q    <= bl_i;
      acc_h_q <= '0;
      acc_l_q <= '0;
    end else if (busy_q) begin
      a_q <= {a_q[rcd_pkg::UM_W-2:0], 1'b0};
      if (a_q[rcd_pkg::UM_W-1]) begin
        acc_h_q <= {acc_h_q[rcd_pkg::ACCH_W-2:0], 1'b0} + rcd_pkg::ACCH_W'(bh_q);
        acc_l_q <= {acc_l_q[rcd_pkg::ACCL_W-2:0], 1'b0} + rcd_pkg::ACCL_W'(bl_q);
      end else begin
        acc_h_q <= {acc_h_q[rcd_pkg::ACCH_W-2:0], 1'b0};
        acc_l_q <= {acc_l_q[rcd_pkg::ACCL_W-2:0], 1'b0};
      end
    end
  end

  assign done_o  = done_q;
  assign acc_h_o = acc_h_q;
  assign acc_l_o = acc_l_q;

endmodule

### hw/rtl/rcd_center_table.sv
// rcd_center_table: stored centers in a synchronous memory, duplicate scan and insert
// depends on rcd_pkg for widths, status codes and the result struct

module rcd_center_table (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start_i,
  input  logic [rcd_pkg::COORD_BITS-1:0]  cx_i,
  input  logic [rcd_pkg::COORD_BITS-1:0]  cy_i,
  input  logic [rcd_pkg::MARGIN_BITS-1:0] margin_x_i,
  input  logic [rcd_pkg::MARGIN_BITS-1:0] margin_y_i,
  output logic                            done_o,
  output rcd_pkg::tbl_res_t               res_o
);

  localparam int unsigned CB = rcd_pkg::COORD_BITS;

  logic [2*CB-1:0]                 mem_q [rcd_pkg::TABLE_DEPTH];
  logic [2*CB-1:0]                 rdata_q;
  logic [rcd_pkg::CNT_BITS-1:0]    count_q;
  logic [rcd_pkg::CNT_BITS-1:0]    rd_idx_q;
  logic [rcd_pkg::SLOT_BITS-1:0]   cmp_idx_q;
  logic                            active_q;
  logic                            cmp_v_q;
  logic                            done_q;
  rcd_pkg::tbl_res_t               res_q;

  logic [CB-1:0]                   tx;
  logic [CB-1:0]                   ty;
  logic [CB-1:0]                   ddx;
  logic [CB-1:0]                   ddy;
  logic                            match;
  logic                            hit;
  logic                            rd_more;
  logic                            re;
  logic                            finish_nf;
  logic                            full;
  logic                            we;

  // distance test on the entry read last cycle
  always_comb begin
    tx    = rdata_q[2*CB-1:CB];
    ty    = rdata_q[CB-1:0];
    ddx   = (tx > cx_i) ? tx - cx_i : cx_i - tx;
    ddy   = (ty > cy_i) ? ty - cy_i : cy_i - ty;
    match = (rcd_pkg::CMP_W'(ddx) < rcd_pkg::CMP_W'(margin_x_i)) &&
            (rcd_pkg::CMP_W'(ddy) < rcd_pkg::CMP_W'(margin_y_i));
  end

  // scan control
  assign hit       = active_q && cmp_v_q && match;
  assign rd_more   = rd_idx_q < count_q;
  assign re        = active_q && rd_more && !hit;
  assign finish_nf = active_q && !cmp_v_q && !rd_more;
  assign full      = count_q == rcd_pkg::CNT_BITS'(rcd_pkg::TABLE_DEPTH);
  assign we        = finish_nf && !full;

  // center memory, one read and one write port
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem_q[count_q[rcd_pkg::SLOT_BITS-1:0]] <= {cx_i, cy_i};
    end
    if (re) begin
      rdata_q <= mem_q[rd_idx_q[rcd_pkg::SLOT_BITS-1:0]];
    end
  end

  // scan state and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      active_q <= 1'b0;
      cmp_v_q  <= 1'b0;
      done_q   <= 1'b0;
      rd_idx_q <= '0;
      count_q  <= '0;
    end else begin
      done_q <= !start_i && (hit || finish_nf);
      if (start_i) begin
        active_q <= 1'b1;
        cmp_v_q  <= 1'b0;
        rd_idx_q <= '0;
      end else if (active_q) begin
        if (hit || finish_nf) begin
          active_q <= 1'b0;
          cmp_v_q  <= 1'b0;
        end else begin
          cmp_v_q <= rd_more;
          if (rd_more) begin
            rd_idx_q <= rd_idx_q + 1'b1;
          end
        end
      end
      if (we) begin
        count_q <= count_q + 1'b1;
      end
    end
  end

  // slot tag and outcome
  always_ff @(posedge clk_i) begin
    if (re) begin
      cmp_idx_q <= rd_idx_q[rcd_pkg::SLOT_BITS-1:0];
    end
    if (hit) begin
      res_q.status <= rcd_pkg::STAT_DUP;
      res_q.slot   <= cmp_idx_q;
    end else if (finish_nf) begin
      if (full) begin
        res_q.status <= rcd_pkg::STAT_FULL;
        res_q.slot   <= '0;
      end else begin
        res_q.status <= rcd_pkg::STAT_UNIQUE;
        res_q.slot   <= count_q[rcd_pkg::SLOT_BITS-1:0];
      end
    end
  end

  assign done_o = done_q;
  assign res_o  = res_q;

endmodule

### hw/rtl/rectangle_center_dedup_top.sv
// rectangle_center_dedup_top: sequencer, fixed point datapath and output register
// depends on rcd_pkg, rcd_if, rcd_div, rcd_mul and rcd_center_table
//
// Usage: each request on in_i carries the four corners of one quadrilateral.
// The block intersects diagonals 0-2 and 1-3 in Q16 fixed point, truncates
// and clamps the crossing, then scans the stored centers. One result per
// request leaves on out_o: unique (stored), duplicate, no center or full.
// Margins are written through cfg_we_i/cfg_idx_i/cfg_data_i; the user must
// do so only while idle, the block itself does not enforce it. In order, the
// divider forms the two slopes and then the crossing division, the multiplier
// forms the y product, the memory scan runs and the result goes into the
// output register; a vertical or near-parallel pair finishes early. One
// request is worked on at a time and the next can be accepted in the cycle
// after the result register loads; the serial divider and the one-entry-per-cycle
// memory scan set the pace.
// The output register holds a finished result while a new request is
// accepted; if the receiver stalls, the next result waits in the last step
// until the register drains.
// Reset clears the fill count (the table reads as empty), the margins go to
// 10 and the result channel drops valid.

module rectangle_center_dedup_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  rcd_in_if.sink                            in_i,
  rcd_out_if.source                         out_o,
  input  logic                              cfg_we_i,
  input  logic [rcd_pkg::CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  logic [rcd_pkg::CFG_DATA_BITS-1:0] cfg_data_i
);

  localparam int unsigned CB = rcd_pkg::COORD_BITS;
  localparam int unsigned FR = rcd_pkg::FRAC;

  rcd_pkg::state_e state_q, state_d;

  // request and datapath registers
  logic [CB-1:0]                      c_q [8];
  logic                               diag_q;
  logic [CB-1:0]                      fx_q;
  logic [CB-1:0]                      fy_q;
  logic                               dyneg_q;
  logic signed [rcd_pkg::M_W-1:0]     m1_q;
  logic signed [rcd_pkg::M_W-1:0]     m2_q;
  logic signed [rcd_pkg::A_W-1:0]     a1_q;
  logic signed [rcd_pkg::A_W-1:0]     a2_q;
  logic                               xsign_q;
  logic [rcd_pkg::DVD_W-1:0]          xmag_q;
  logic [rcd_pkg::Y_W-1:0]            p_q;
  logic [CB-1:0]                      cx_q;
  logic [CB-1:0]                      cy_q;
  rcd_pkg::status_e                   rs_q;
  logic [rcd_pkg::SLOT_BITS-1:0]      rslot_q;
  logic [rcd_pkg::MARGIN_BITS-1:0]    margin_x_q;
  logic [rcd_pkg::MARGIN_BITS-1:0]    margin_y_q;

  // output register
  logic                               ov_q;
  rcd_pkg::status_e                   os_q;
  logic [CB-1:0]                      ocx_q;
  logic [CB-1:0]                      ocy_q;
  logic [rcd_pkg::SLOT_BITS-1:0]      oslot_q;
  logic                               out_free;

  // combinational datapath
  logic [CB-1:0]                      px, py, qx, qy;
  logic                               p_first;
  logic [CB-1:0]                      fx, fy, sx, sy, dx;
  logic signed [CB:0]                 dy_s;
  logic [CB:0]                        dy_neg_v;
  logic [CB-1:0]                      dy_mag;
  logic signed [rcd_pkg::M_W-1:0]     m_pos;
  logic signed [rcd_pkg::M_W-1:0]     m_new;
  logic signed [rcd_pkg::M_W-1:0]     m_cur;
  logic signed [rcd_pkg::A_W-1:0]     fx_ext, m_ext, prod, fy_sh, a_new;
  logic signed [rcd_pkg::DEN_W-1:0]   den, den_abs;
  logic signed [rcd_pkg::NUM_W-1:0]   num, num_abs;
  logic [rcd_pkg::UD_W-1:0]           ud;
  logic [rcd_pkg::UN_W-1:0]           un;
  logic                               too_flat;
  logic signed [rcd_pkg::M_W-1:0]     m1_abs;
  logic [rcd_pkg::UM_W-1:0]           um;
  logic                               xneg;
  logic [rcd_pkg::SAT_W-1:0]          acc_ext;
  logic                               sat;
  logic [rcd_pkg::Y_W-1:0]            p_new;
  logic signed [rcd_pkg::Y_W-1:0]     yq;
  logic [CB-1:0]                      cx_new, cy_new;

  // unit connections
  rcd_pkg::div_cmd_t                  div_cmd;
  logic [rcd_pkg::DVD_W-1:0]          div_dvd;
  logic [rcd_pkg::UD_W-1:0]           div_dsr;
  logic                               div_done;
  logic [rcd_pkg::DVD_W-1:0]          div_quot;
  logic                               mul_start;
  logic                               mul_done;
  logic [rcd_pkg::ACCH_W-1:0]         acc_h;
  logic [rcd_pkg::ACCL_W-1:0]         acc_l;
  logic                               tbl_start;
  logic                               tbl_done;
  rcd_pkg::tbl_res_t                  tbl_res;

  // diagonal endpoints, ordered by x
  always_comb begin
    px       = diag_q ? c_q[2] : c_q[0];
    py       = diag_q ? c_q[3] : c_q[1];
    qx       = diag_q ? c_q[6] : c_q[4];
    qy       = diag_q ? c_q[7] : c_q[5];
    p_first  = px >= qx;
    fx       = p_first ? px : qx;
    fy       = p_first ? py : qy;
    sx       = p_first ? qx : px;
    sy       = p_first ? qy : py;
    dx       = fx - sx;
    dy_s     = $signed({1'b0, fy}) - $signed({1'b0, sy});
    dy_neg_v = -dy_s;
    dy_mag   = dy_s[CB] ? dy_neg_v[CB-1:0] : dy_s[CB-1:0];
  end

  // slope sign and intercept
  always_comb begin
    m_pos  = $signed({1'b0, div_quot[rcd_pkg::UM_W-1:0]});
    m_new  = dyneg_q ? -m_pos : m_pos;
    m_cur  = diag_q ? m2_q : m1_q;
    fx_ext = $signed({{(rcd_pkg::A_W-CB){1'b0}}, fx_q});
    m_ext  = rcd_pkg::A_W'(m_cur);
    prod   = fx_ext * m_ext;
    fy_sh  = $signed({{(rcd_pkg::A_W-CB-FR){1'b0}}, fy_q, {FR{1'b0}}});
    a_new  = fy_sh - prod;
  end

  // crossing operands
  always_comb begin
    den      = rcd_pkg::DEN_W'(m1_q) - rcd_pkg::DEN_W'(m2_q);
    den_abs  = den[rcd_pkg::DEN_W-1] ? -den : den;
    ud       = den_abs[rcd_pkg::UD_W-1:0];
    num      = rcd_pkg::NUM_W'(a2_q) - rcd_pkg::NUM_W'(a1_q);
    num_abs  = num[rcd_pkg::NUM_W-1] ? -num : num;
    un       = num_abs[rcd_pkg::UN_W-1:0];
    too_flat = ud < rcd_pkg::UD_W'(rcd_pkg::SLOPE_EPS);
    m1_abs   = m1_q[rcd_pkg::M_W-1] ? -m1_q : m1_q;
    um       = m1_abs[rcd_pkg::UM_W-1:0];
    xneg     = xsign_q && (xmag_q != '0);
  end

  // saturated y product
  always_comb begin
    acc_ext = rcd_pkg::SAT_W'(acc_h);
    sat     = acc_ext > (rcd_pkg::SAT_W'(1) << rcd_pkg::SAT_SHIFT);
    if (sat) begin
      p_new = rcd_pkg::Y_W'(1) << rcd_pkg::SAT_SHIFT;
    end else begin
      p_new = rcd_pkg::Y_W'(acc_h) + rcd_pkg::Y_W'(acc_l >> FR);
    end
  end

  // center, truncated and clamped
  always_comb begin
    if ((m1_q[rcd_pkg::M_W-1]) != xneg) begin
      yq = rcd_pkg::Y_W'(a1_q) - $signed(p_q);
    end else begin
      yq = rcd_pkg::Y_W'(a1_q) + $signed(p_q);
    end
    if (xneg) begin
      cx_new = '0;
    end else if (|xmag_q[rcd_pkg::DVD_W-1:FR+CB]) begin
      cx_new = '1;
    end else begin
      cx_new = xmag_q[FR+CB-1:FR];
    end
    if (yq[rcd_pkg::Y_W-1]) begin
      cy_new = '0;
    end else if (|yq[rcd_pkg::Y_W-2:FR+CB]) begin
      cy_new = '1;
    end else begin
      cy_new = yq[FR+CB-1:FR];
    end
  end

  assign out_free = !ov_q || out_o.ready;

  // next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      rcd_pkg::ST_IDLE:   if (in_i.valid) state_d = rcd_pkg::ST_FIT;
      rcd_pkg::ST_FIT:    state_d = (dx == '0) ? rcd_pkg::ST_DONE : rcd_pkg::ST_SLOPE;
      rcd_pkg::ST_SLOPE:  if (div_done) state_d = rcd_pkg::ST_ICEPT;
      rcd_pkg::ST_ICEPT:  state_d = diag_q ? rcd_pkg::ST_CROSS : rcd_pkg::ST_FIT;
      rcd_pkg::ST_CROSS:  state_d = too_flat ? rcd_pkg::ST_DONE : rcd_pkg::ST_XDIV;
      rcd_pkg::ST_XDIV:   if (div_done) state_d = rcd_pkg::ST_MUL;
      rcd_pkg::ST_MUL:    if (mul_done) state_d = rcd_pkg::ST_YCALC;
      rcd_pkg::ST_YCALC:  state_d = rcd_pkg::ST_TSTART;
      rcd_pkg::ST_TSTART: state_d = rcd_pkg::ST_SCAN;
      rcd_pkg::ST_SCAN:   if (tbl_done) state_d = rcd_pkg::ST_DONE;
      rcd_pkg::ST_DONE:   if (out_free) state_d = rcd_pkg::ST_IDLE;
      default:            state_d = rcd_pkg::ST_IDLE;
    endcase
  end

  // unit controls
  always_comb begin
    in_i.ready    = (state_q == rcd_pkg::ST_IDLE);
    div_cmd.start = 1'b0;
    div_cmd.steps = rcd_pkg::STEP_W'(CB + FR);
    div_dvd       = {dy_mag, {(rcd_pkg::DVD_W-CB){1'b0}}};
    div_dsr       = rcd_pkg::UD_W'(dx);
    if (state_q == rcd_pkg::ST_FIT) begin
      div_cmd.start = (dx != '0);
    end else if (state_q == rcd_pkg::ST_CROSS) begin
      div_cmd.start = !too_flat;
      div_cmd.steps = rcd_pkg::STEP_W'(rcd_pkg::DVD_W);
      div_dvd       = {un, {FR{1'b0}}};
      div_dsr       = ud;
    end
    mul_start = (state_q == rcd_pkg::ST_XDIV) && div_done;
    tbl_start = (state_q == rcd_pkg::ST_TSTART);
  end

  // state and configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= rcd_pkg::ST_IDLE;
      margin_x_q <= rcd_pkg::MARGIN_BITS'(rcd_pkg::MARGIN_RESET);
      margin_y_q <= rcd_pkg::MARGIN_BITS'(rcd_pkg::MARGIN_RESET);
      ov_q       <= 1'b0;
    end else begin
      state_q <= state_d;
      if (cfg_we_i) begin
        unique case (rcd_pkg::cfg_idx_e'(cfg_idx_i))
          rcd_pkg::CFG_MARGIN_X: margin_x_q <= cfg_data_i;
          rcd_pkg::CFG_MARGIN_Y: margin_y_q <= cfg_data_i;
        endcase
      end
      if (state_q == rcd_pkg::ST_DONE && out_free) begin
        ov_q <= 1'b1;
      end else if (out_o.ready) begin
        ov_q <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      rcd_pkg::ST_IDLE: begin
        diag_q <= 1'b0;
        c_q[0] <= in_i.corner0_x;
        c_q[1] <= in_i.corner0_y;
        c_q[2] <= in_i.corner1_x;
        c_q[3] <= in_i.corner1_y;
        c_q[4] <= in_i.corner2_x;
        c_q[5] <= in_i.corner2_y;
        c_q[6] <= in_i.corner3_x;
        c_q[7] <= in_i.corner3_y;
      end
      rcd_pkg::ST_FIT: begin
        fx_q    <= fx;
        fy_q    <= fy;
        dyneg_q <= dy_s[CB];
        if (dx == '0) begin
          rs_q    <= rcd_pkg::STAT_NOCENTER;
          cx_q    <= '0;
          cy_q    <= '0;
          rslot_q <= '0;
        end
      end
      rcd_pkg::ST_SLOPE: begin
        if (div_done) begin
          if (diag_q) begin
            m2_q <= m_new;
          end else begin
            m1_q <= m_new;
          end
        end
      end
      rcd_pkg::ST_ICEPT: begin
        if (diag_q) begin
          a2_q <= a_new;
        end else begin
          a1_q   <= a_new;
          diag_q <= 1'b1;
        end
      end
      rcd_pkg::ST_CROSS: begin
        xsign_q <= num[rcd_pkg::NUM_W-1] != den[rcd_pkg::DEN_W-1];
        if (too_flat) begin
          rs_q    <= rcd_pkg::STAT_NOCENTER;
          cx_q    <= '0;
          cy_q    <= '0;
          rslot_q <= '0;
        end
      end
      rcd_pkg::ST_XDIV: begin
        if (div_done) begin
          xmag_q <= div_quot;
        end
      end
      rcd_pkg::ST_MUL: begin
        if (mul_done) begin
          p_q <= p_new;
        end
      end
      rcd_pkg::ST_YCALC: begin
        cx_q <= cx_new;
        cy_q <= cy_new;
      end
      rcd_pkg::ST_SCAN: begin
        if (tbl_done) begin
          rs_q    <= tbl_res.status;
          rslot_q <= tbl_res.slot;
        end
      end
      rcd_pkg::ST_DONE: begin
        if (out_free) begin
          os_q    <= rs_q;
          ocx_q   <= cx_q;
          ocy_q   <= cy_q;
          oslot_q <= rslot_q;
        end
      end
      default: begin
      end
    endcase
  end

  // shared serial divider
  rcd_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cmd_i      (div_cmd),
    .dividend_i (div_dvd),
    .divisor_i  (div_dsr),
    .done_o     (div_done),
    .quot_o     (div_quot)
  );

  // y product multiplier
  rcd_mul u_mul (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .start_i (mul_start),
    .a_i     (um),
    .bh_i    (div_quot[rcd_pkg::DVD_W-1:FR]),
    .bl_i    (div_quot[FR-1:0]),
    .done_o  (mul_done),
    .acc_h_o (acc_h),
    .acc_l_o (acc_l)
  );

  // stored centers
  rcd_center_table u_table (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (tbl_start),
    .cx_i       (cx_q),
    .cy_i       (cy_q),
    .margin_x_i (margin_x_q),
    .margin_y_i (margin_y_q),
    .done_o     (tbl_done),
    .res_o      (tbl_res)
  );

  // result channel
  assign out_o.valid      = ov_q;
  assign out_o.status     = os_q;
  assign out_o.center_x   = ocx_q;
  assign out_o.center_y   = ocy_q;
  assign out_o.match_slot = oslot_q;

endmodule

### verif/rcd_center_checker.sv
// rcd_center_checker: watches the request, result and margin write ports, predicts each center
// result and compares it field by field; depends on rcd_pkg and rcd_if

module rcd_center_checker (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  rcd_in_if                                 in_m,
  rcd_out_if                                out_m,
  input  logic                              cfg_we_i,
  input  logic [rcd_pkg::CFG_IDX_BITS-1:0]  cfg_idx_i,
  input  logic [rcd_pkg::CFG_DATA_BITS-1:0] cfg_data_i,
  output int                                errors_o,
  output int                                pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned CB = rcd_pkg::COORD_BITS;
  localparam int unsigned MB = rcd_pkg::MARGIN_BITS;
  localparam int unsigned SB = rcd_pkg::SLOT_BITS;

  typedef struct packed {
    rcd_pkg::status_e status;
    logic [CB-1:0]    cx;
    logic [CB-1:0]    cy;
    logic [SB-1:0]    slot;
  } center_res_t;

  center_res_t           expected_centers[$];
  logic [MB-1:0]         mgn_x = MB'(rcd_pkg::MARGIN_RESET);
  logic [MB-1:0]         mgn_y = MB'(rcd_pkg::MARGIN_RESET);
  logic [CB-1:0]         stored_x[rcd_pkg::TABLE_DEPTH];
  logic [CB-1:0]         stored_y[rcd_pkg::TABLE_DEPTH];
  int                    stored_cnt = 0;

  initial errors_o = 0;
  assign pending_o = expected_centers.size();

  function automatic longint unsigned abs64(longint v);
    return (v < 0) ? longint'(0) - v : v;
  endfunction

  // slope and intercept in q16, ends ordered by x
  function automatic bit fit_line(longint px, longint py, longint qx, longint qy,
                                  output longint m, output longint a);
    longint fx, fy, sx, sy;
    fx = (px >= qx) ? px : qx;
    fy = (px >= qx) ? py : qy;
    sx = (px >= qx) ? qx : px;
    sy = (px >= qx) ? qy : py;
    m = 0;
    a = 0;
    if (fx == sx) return 0;
    m = ((fy - sy) * 65536) / (fx - sx);
    a = fy * 65536 - fx * m;
    return 1;
  endfunction

  function automatic logic [CB-1:0] q16_to_coord(longint q);
    longint v;
    if (q < 0) return '0;
    v = q / 65536;
    return (v > (1 << CB) - 1) ? {CB{1'b1}} : v[CB-1:0];
  endfunction

  // crossing of the diagonals, then table lookup and update
  function automatic center_res_t locate_center(longint c[8]);
    center_res_t res;
    longint m1, a1, m2, a2, num, den, xq, yq;
    longint unsigned un, ud, xmag, um, xh, xl, prod, ddx, ddy;
    bit hit;
    res = '{rcd_pkg::STAT_NOCENTER, '0, '0, '0};
    hit = 0;
    if (!fit_line(c[0], c[1], c[4], c[5], m1, a1)) return res;
    if (!fit_line(c[2], c[3], c[6], c[7], m2, a2)) return res;
    if (abs64(m2 - m1) < rcd_pkg::SLOPE_EPS) return res;
    den = m1 - m2;
    num = a2 - a1;
    un = abs64(num);
    ud = abs64(den);
    xmag = (un / ud) * 65536 + ((un % ud) * 65536) / ud;
    xq = ((num < 0) != (den < 0)) ? -longint'(xmag) : longint'(xmag);
    um = abs64(m1);
    xh = xmag >> 16;
    xl = xmag & 64'hFFFF;
    if (xh != 0 && um > (64'd1 << 60) / xh) prod = 64'd1 << 60;
    else prod = um * xh + ((um * xl) >> 16);
    yq = ((m1 < 0) != (xq < 0)) ? a1 - longint'(prod) : a1 + longint'(prod);
    res.cx = q16_to_coord(xq);
    res.cy = q16_to_coord(yq);
    for (int i = 0; i < stored_cnt && !hit; i++) begin
      ddx = (stored_x[i] > res.cx) ? stored_x[i] - res.cx : res.cx - stored_x[i];
      ddy = (stored_y[i] > res.cy) ? stored_y[i] - res.cy : res.cy - stored_y[i];
      if (ddx < mgn_x && ddy < mgn_y) begin
        hit = 1;
        res.slot = SB'(i);
      end
    end
    if (hit) begin
      res.status = rcd_pkg::STAT_DUP;
    end else if (stored_cnt >= rcd_pkg::TABLE_DEPTH) begin
      res.status = rcd_pkg::STAT_FULL;
    end else begin
      res.status = rcd_pkg::STAT_UNIQUE;
      res.slot = SB'(stored_cnt);
      stored_x[stored_cnt] = res.cx;
      stored_y[stored_cnt] = res.cy;
      stored_cnt++;
    end
    return res;
  endfunction

  task automatic report_mismatch(string what, longint got, longint want);
    $display("%0t: center result %s mismatch: got %0d, want %0d", $realtime, what, got, want);
    errors_o++;
  endtask

  // margin writes, accepted requests and results
  always @(posedge clk_i) begin
    longint      corners[8];
    center_res_t want;
    if (rst_ni) begin
      if (cfg_we_i) begin
        if (cfg_idx_i == rcd_pkg::CFG_MARGIN_X) mgn_x = cfg_data_i;
        else if (cfg_idx_i == rcd_pkg::CFG_MARGIN_Y) mgn_y = cfg_data_i;
      end
      if (in_m.valid && in_m.ready) begin
        corners = '{in_m.corner0_x, in_m.corner0_y, in_m.corner1_x, in_m.corner1_y,
                    in_m.corner2_x, in_m.corner2_y, in_m.corner3_x, in_m.corner3_y};
        expected_centers = {expected_centers, locate_center(corners)};
      end
      if (out_m.valid && out_m.ready) begin
        if (expected_centers.size() == 0) begin
          $display("%0t: center result with no request outstanding", $realtime);
          errors_o++;
        end else begin
          want = expected_centers.pop_front();
          if (out_m.status !== want.status) report_mismatch("status", out_m.status, want.status);
          if (out_m.center_x !== want.cx) report_mismatch("center_x", out_m.center_x, want.cx);
          if (out_m.center_y !== want.cy) report_mismatch("center_y", out_m.center_y, want.cy);
          if (out_m.match_slot !== want.slot)
            report_mismatch("match_slot", out_m.match_slot, want.slot);
        end
      end
    end
  end
endmodule

### verif/rectangle_center_dedup_top_tb.sv
// rectangle_center_dedup_top_tb: quadrilateral request stimulus, stalls and verdict
// depends on rcd_pkg, rcd_if, the block and rcd_center_checker

module rectangle_center_dedup_top_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int IDLE_LIMIT = 20000;
  localparam int PHASE_ITEMS = 300;
  localparam int unsigned CB = rcd_pkg::COORD_BITS;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic cfg_we_i = 1'b0;
  logic [rcd_pkg::CFG_IDX_BITS-1:0] cfg_idx_i = rcd_pkg::CFG_MARGIN_X;
  logic [rcd_pkg::CFG_DATA_BITS-1:0] cfg_data_i = '0;
  int errors;
  int pending;
  int idle_cycles = 0;
  int pool_x[48];
  int pool_y[48];

  rcd_in_if  in_ch ();
  rcd_out_if out_ch ();

  rectangle_center_dedup_top u_dut (
    .clk_i, .rst_ni, .in_i(in_ch), .out_o(out_ch), .cfg_we_i, .cfg_idx_i, .cfg_data_i
  );

  rcd_center_checker u_checker (
    .clk_i, .rst_ni, .in_m(in_ch), .out_m(out_ch), .cfg_we_i, .cfg_idx_i, .cfg_data_i,
    .errors_o(errors), .pending_o(pending)
  );

  // clock
  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // receiver stalls: runs of ready and not ready, some long free stretches
  initial begin
    int run;
    out_ch.ready = 1'b0;
    forever begin
      run = $urandom_range(1, ($urandom_range(0, 3) == 0) ? 400 : 15);
      repeat (run) @(negedge clk_i) out_ch.ready <= 1'b1;
      run = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 40);
      repeat (run) @(negedge clk_i) out_ch.ready <= 1'b0;
    end
  end

  // watchdog on cycles with no handshake
  always @(posedge clk_i) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles > IDLE_LIMIT) begin
      $display("rectangle_center_dedup_top_tb: errors");
      $finish;
    end
  end

  function automatic int clip(int v);
    return (v < 0) ? 0 : (v > 4095) ? 4095 : v;
  endfunction

  // one request, held until accepted
  task automatic send_quad(int x0, int y0, int x1, int y1, int x2, int y2, int x3, int y3);
    bit taken;
    in_ch.valid <= 1'b1;
    in_ch.corner0_x <= CB'(x0); in_ch.corner0_y <= CB'(y0);
    in_ch.corner1_x <= CB'(x1); in_ch.corner1_y <= CB'(y1);
    in_ch.corner2_x <= CB'(x2); in_ch.corner2_y <= CB'(y2);
    in_ch.corner3_x <= CB'(x3); in_ch.corner3_y <= CB'(y3);
    taken = 0;
    while (!taken) begin
      @(posedge clk_i);
      taken = in_ch.valid && in_ch.ready;
    end
    @(negedge clk_i);
  endtask

  // quadrilateral around a center, diagonals 0-2 and 1-3 cross near it
  task automatic send_around(int cx, int cy);
    int a, b, c, d;
    a = $urandom_range(1, 300); b = $urandom_range(0, 300);
    c = $urandom_range(1, 300); d = $urandom_range(0, 300);
    send_quad(clip(cx - a), clip(cy - b), clip(cx + c), clip(cy - d),
              clip(cx + a), clip(cy + b), clip(cx - c), clip(cy + d));
  endtask

  task automatic write_margin(rcd_pkg::cfg_idx_e idx, int val);
    wait (pending == 0);
    @(negedge clk_i);
    cfg_we_i <= 1'b1; cfg_idx_i <= idx; cfg_data_i <= rcd_pkg::CFG_DATA_BITS'(val);
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  initial begin
    int burst;
    int gap;
    int mx[5] = '{10, 1, 4095, 1, 200};
    int my[5] = '{10, 1, 4095, 4095, 30};
    in_ch.valid = 1'b0;
    {in_ch.corner0_x, in_ch.corner0_y, in_ch.corner1_x, in_ch.corner1_y} = '0;
    {in_ch.corner2_x, in_ch.corner2_y, in_ch.corner3_x, in_ch.corner3_y} = '0;
    foreach (pool_x[i]) begin
      pool_x[i] = $urandom_range(0, 4095);
      pool_y[i] = $urandom_range(0, 4095);
    end
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // directed: degenerate, extreme and saturating shapes
    send_quad(0, 0, 0, 0, 0, 0, 0, 0);
    send_quad(4095, 4095, 4095, 4095, 4095, 4095, 4095, 4095);
    send_quad(0, 0, 4095, 0, 4095, 4095, 0, 4095);
    send_quad(0, 0, 4095, 0, 4095, 4095, 0, 4095);
    send_quad(5, 0, 0, 9, 5, 4095, 4095, 9);
    send_quad(0, 0, 4, 0, 4095, 4095, 4099 - 4095, 100);
    send_quad(0, 0, 0, 1, 4095, 4095, 4095, 4094);
    send_quad(0, 0, 1, 4095, 4095, 10, 2, 0);
    send_quad(4094, 0, 4095, 4095, 4095, 1, 4094, 4094);
    send_quad(0, 4095, 1, 4094, 1, 4094, 0, 4095);
    send_quad(100, 100, 300, 100, 300, 300, 100, 300);
    send_quad(105, 95, 295, 105, 295, 305, 105, 295);
    send_quad(0, 4095, 4095, 4095, 4095, 0, 0, 0);
    send_quad(4095, 0, 0, 0, 0, 4095, 4095, 4095);
    in_ch.valid <= 1'b0;

    // random phases with margin changes while idle
    for (int ph = 0; ph < 5; ph++) begin
      write_margin(rcd_pkg::CFG_MARGIN_X, mx[ph]);
      write_margin(rcd_pkg::CFG_MARGIN_Y, my[ph]);
      for (int n = 0; n < PHASE_ITEMS; ) begin
        burst = $urandom_range(1, 20);
        gap = ($urandom_range(0, 2) != 0) ? $urandom_range(1, 30) : 0;
        for (int k = 0; k < burst && n < PHASE_ITEMS; k++, n++) begin
          if ($urandom_range(0, 4) == 0)
            send_quad($urandom_range(0, 4095), $urandom_range(0, 4095),
                      $urandom_range(0, 4095), $urandom_range(0, 4095),
                      $urandom_range(0, 4095), $urandom_range(0, 4095),
                      $urandom_range(0, 4095), $urandom_range(0, 4095));
          else if ($urandom_range(0, 9) == 0)
            send_around($urandom_range(0, 4095), $urandom_range(0, 4095));
          else begin
            burst = burst;
            send_around(pool_x[n % 48] + $urandom_range(0, 6) - 3,
                        pool_y[n % 48] + $urandom_range(0, 6) - 3);
          end
        end
        if (gap != 0 || n >= PHASE_ITEMS) in_ch.valid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end

    // drain
    wait (pending == 0);
    repeat (300) @(posedge clk_i);
    if (errors == 0) $display("rectangle_center_dedup_top_tb: clean");
    else $display("rectangle_center_dedup_top_tb: errors");
    $finish;
  end
endmodule
